@@ rtl/core/stt_pkg.sv @@
`default_nettype none
package stt_pkg;

    localparam int OFFSET_BITS_DEF   = 16;
    localparam int KEYWORD_CHARS_DEF = 8;
    localparam logic [15:0] LINE_MAX = 16'hFFFF;

    localparam logic [5:0] K_IDENT  = 6'd0;
    localparam logic [5:0] K_NUMBER = 6'd1;
    localparam logic [5:0] K_STRING = 6'd2;
    localparam logic [5:0] K_EOF    = 6'd3;
    localparam logic [5:0] K_COLON  = 6'd13;
    localparam logic [5:0] K_COLBR  = 6'd14;
    localparam logic [5:0] K_LT     = 6'd21;
    localparam logic [5:0] K_LE     = 6'd22;
    localparam logic [5:0] K_GT     = 6'd23;
    localparam logic [5:0] K_GE     = 6'd24;
    localparam logic [5:0] K_ASSIGN = 6'd25;
    localparam logic [5:0] K_EQEQ   = 6'd26;
    localparam logic [5:0] K_NE     = 6'd27;
    localparam logic [5:0] K_BANG   = 6'd28;
    localparam logic [5:0] K_ERROR  = 6'd58;

    localparam logic [1:0] E_NONE   = 2'd0;
    localparam logic [1:0] E_UNTERM = 2'd1;
    localparam logic [1:0] E_UNEXP  = 2'd2;

    typedef enum logic [3:0] {
        M_IDLE, M_COMMENT, M_IDENT, M_INT, M_FRAC, M_STRING,
        M_COLON, M_LT, M_GT, M_EQ, M_BANG
    } mode_t;

    typedef struct packed {
        logic [5:0]  kind;
        logic [1:0]  err;
        logic [15:0] start;
        logic [15:0] len;
        logic [15:0] line;
    } tok_t;

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic [5:0] single_kind(input logic [7:0] c);
        case (c)
            "(": return 6'd4;
            ")": return 6'd5;
            "{": return 6'd6;
            "}": return 6'd7;
            "[": return 6'd8;
            "]": return 6'd9;
            ",": return 6'd10;
            ".": return 6'd11;
            ";": return 6'd12;
            "+": return 6'd15;
            "-": return 6'd16;
            "*": return 6'd17;
            "/": return 6'd18;
            "%": return 6'd19;
            "^": return 6'd20;
            default: return 6'd0;
        endcase
    endfunction

    function automatic logic [63:0] kw(input string s);
        logic [63:0] w;
        w = '0;
        for (int i = 0; i < 8; i++)
            if (i < s.len()) w[8*i +: 8] = s[i];
        return w;
    endfunction

    function automatic logic [5:0] ident_kind(input logic [63:0] w, input logic [3:0] n);
        logic [5:0] k;
        k = K_IDENT;
        case (n)
            4'd2: begin
                if (w[15:0] == kw("do")) k = 6'd37;
                if (w[15:0] == kw("if")) k = 6'd44;
                if (w[15:0] == kw("in")) k = 6'd45;
                if (w[15:0] == kw("or")) k = 6'd47;
            end
            4'd3: begin
                if (w[23:0] == kw("and")) k = 6'd29;
                if (w[23:0] == kw("end")) k = 6'd40;
                if (w[23:0] == kw("for")) k = 6'd42;
                if (w[23:0] == kw("nil")) k = 6'd46;
                if (w[23:0] == kw("var")) k = 6'd54;
                if (w[23:0] == kw("xor")) k = 6'd57;
                if (w[23:0] == kw("not")) k = K_BANG;
            end
            4'd4: begin
                if (w[31:0] == kw("atom")) k = 6'd30;
                if (w[31:0] == kw("case")) k = 6'd32;
                if (w[31:0] == kw("each")) k = 6'd38;
                if (w[31:0] == kw("else")) k = 6'd39;
                if (w[31:0] == kw("true")) k = 6'd52;
                if (w[31:0] == kw("when")) k = 6'd55;
            end
            4'd5: begin
                if (w[39:0] == kw("break")) k = 6'd31;
                if (w[39:0] == kw("false")) k = 6'd41;
                if (w[39:0] == kw("state")) k = 6'd49;
                if (w[39:0] == kw("table")) k = 6'd51;
                if (w[39:0] == kw("while")) k = 6'd56;
            end
            4'd6: begin
                if (w[47:0] == kw("switch")) k = 6'd50;
            end
            4'd7: begin
                if (w[55:0] == kw("compare")) k = 6'd33;
                if (w[55:0] == kw("default")) k = 6'd36;
                if (w[55:0] == kw("program")) k = 6'd48;
                if (w[55:0] == kw("unknown")) k = 6'd53;
            end
            4'd8: begin
                if (w == kw("consider")) k = 6'd34;
                if (w == kw("continue")) k = 6'd35;
                if (w == kw("function")) k = 6'd43;
            end
            default: k = K_IDENT;
        endcase
        return k;
    endfunction

endpackage
`default_nettype wire

@@ rtl/core/source_text_tokenizer.sv @@
`default_nettype none
// Channel   Signals                                          Dir
// input     char_valid char_ready char_byte                  in
// output    token_valid token_ready token_kind error_kind    out
//           start_offset token_length line_number last_of_run
// One byte per cycle; each byte is scanned in a single pass from the input
// register and its zero to two tokens land in a four-entry output queue.
// Input stalls while the queue, after this cycle's push and pop, would hold
// more than two tokens.
// Reset: idle, position 0, line 1. Byte 0 emits EOF and restarts the scan.
module source_text_tokenizer #(
    parameter int OFFSET_BITS   = stt_pkg::OFFSET_BITS_DEF,
    parameter int KEYWORD_CHARS = stt_pkg::KEYWORD_CHARS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        char_valid,
    output logic             char_ready,
    input  wire logic [7:0]  char_byte,
    output logic             token_valid,
    input  wire logic        token_ready,
    output logic [5:0]       token_kind,
    output logic [1:0]       error_kind,
    output logic [15:0]      start_offset,
    output logic [15:0]      token_length,
    output logic [15:0]      line_number,
    output logic             last_of_run
);
    import stt_pkg::*;

    localparam logic [OFFSET_BITS-1:0] CAP = '1;
    localparam int WB = 8 * KEYWORD_CHARS;

    logic                   in_v_reg;
    logic [7:0]             in_c_reg;
    mode_t                  mode_reg, mode_next;
    logic [OFFSET_BITS-1:0] pos_reg, pos_next, st_reg, st_next;
    logic [15:0]            line_reg, line_next;
    logic [WB-1:0]          wb_reg, wb_next;
    logic [3:0]             wl_reg, wl_next;
    logic                   space;
    logic [1:0]             n;
    tok_t                   ta, tb;
    tok_t                   oq;

    assign char_ready = space;

    function automatic logic [15:0] lenf(input logic [OFFSET_BITS-1:0] p,
                                         input logic [OFFSET_BITS-1:0] s,
                                         input logic e);
        logic [OFFSET_BITS:0] l;
        l = {1'b0, p - s} + {{OFFSET_BITS{1'b0}}, e};
        if (l > {1'b0, CAP})
            l = {1'b0, CAP};
        return 16'(l);
    endfunction

    always_comb
    begin
        logic [7:0]  c;
        logic        fl, idl, a, d;
        logic [5:0]  pk, sk;
        tok_t        t0, t1;
        c = in_c_reg;
        mode_next = mode_reg;
        pos_next = pos_reg;
        st_next = st_reg;
        line_next = line_reg;
        wb_next = wb_reg;
        wl_next = wl_reg;
        n = 2'd0;
        ta = '0;
        tb = '0;
        t0 = '0;
        t1 = '0;
        fl = 1'b0;
        idl = 1'b0;
        a = is_alpha(c);
        d = is_digit(c);
        pk = K_IDENT;
        sk = single_kind(c);
        case (mode_reg)
            M_IDENT: pk = ident_kind(wb_reg[63:0], wl_reg);
            M_INT, M_FRAC: pk = K_NUMBER;
            M_STRING: pk = K_ERROR;
            M_COLON: pk = K_COLON;
            M_LT: pk = K_LT;
            M_GT: pk = K_GT;
            M_EQ: pk = K_ASSIGN;
            M_BANG: pk = K_BANG;
            default: pk = K_IDENT;
        endcase
        t0.kind = pk;
        t0.err = (mode_reg == M_STRING) ? E_UNTERM : E_NONE;
        t0.start = 16'(st_reg);
        t0.len = (mode_reg == M_STRING) ? 16'd0 : lenf(pos_reg, st_reg, 1'b0);
        t0.line = line_reg;
        if (in_v_reg)
        begin
            if (c == 8'd0)
            begin
                fl = mode_reg != M_IDLE && mode_reg != M_COMMENT;
                t1.kind = K_EOF;
                t1.err = E_NONE;
                t1.start = 16'(pos_reg);
                t1.len = '0;
                t1.line = line_reg;
                if (fl)
                begin
                    ta = t0;
                    tb = t1;
                    n = 2'd2;
                end
                else
                begin
                    ta = t1;
                    n = 2'd1;
                end
                mode_next = M_IDLE;
                pos_next = '0;
                st_next = '0;
                line_next = 16'd1;
                wb_next = '0;
                wl_next = '0;
            end
            else
            begin
                case (mode_reg)
                    M_IDLE: idl = 1'b1;
                    M_COMMENT: idl = c == 8'h0A;
                    M_IDENT:
                        if (a || d)
                        begin
                            if (wl_reg < 4'(KEYWORD_CHARS))
                                wb_next[wl_reg[2:0]*8 +: 8] = c;
                            if (wl_reg <= 4'(KEYWORD_CHARS))
                                wl_next = wl_reg + 4'd1;
                        end
                        else
                        begin
                            fl = 1'b1;
                            idl = 1'b1;
                        end
                    M_INT:
                        if (c == ".")
                            mode_next = M_FRAC;
                        else if (!d)
                        begin
                            fl = 1'b1;
                            idl = 1'b1;
                        end
                    M_FRAC:
                        if (!d)
                        begin
                            fl = 1'b1;
                            idl = 1'b1;
                        end
                    M_STRING:
                        if (c == "\"")
                        begin
                            ta.kind = K_STRING;
                            ta.err = E_NONE;
                            ta.start = 16'(st_reg);
                            ta.len = lenf(pos_reg, st_reg, 1'b1);
                            ta.line = line_reg;
                            n = 2'd1;
                            mode_next = M_IDLE;
                        end
                        else if (c == 8'h0A && line_reg != LINE_MAX)
                            line_next = line_reg + 16'd1;
                    M_COLON, M_LT, M_GT, M_EQ, M_BANG:
                        if ((mode_reg == M_COLON && c == "[") ||
                            (mode_reg != M_COLON && c == "="))
                        begin
                            ta.kind = (mode_reg == M_COLON) ? K_COLBR :
                                      (mode_reg == M_LT) ? K_LE :
                                      (mode_reg == M_GT) ? K_GE :
                                      (mode_reg == M_EQ) ? K_EQEQ : K_NE;
                            ta.err = E_NONE;
                            ta.start = 16'(st_reg);
                            ta.len = lenf(pos_reg, st_reg, 1'b1);
                            ta.line = line_reg;
                            n = 2'd1;
                            mode_next = M_IDLE;
                        end
                        else
                        begin
                            fl = 1'b1;
                            idl = 1'b1;
                        end
                    default: idl = 1'b1;
                endcase
                if (fl)
                begin
                    ta = t0;
                    n = 2'd1;
                end
                if (idl)
                begin
                    mode_next = M_IDLE;
                    if (c == " " || c == 8'h0D || c == 8'h09)
                        mode_next = M_IDLE;
                    else if (c == 8'h0A)
                    begin
                        if (line_reg != LINE_MAX)
                            line_next = line_reg + 16'd1;
                    end
                    else if (c == "#")
                        mode_next = M_COMMENT;
                    else
                    begin
                        st_next = pos_reg;
                        if (a)
                        begin
                            mode_next = M_IDENT;
                            wb_next = '0;
                            wb_next[7:0] = c;
                            wl_next = 4'd1;
                        end
                        else if (d) mode_next = M_INT;
                        else if (c == "\"") mode_next = M_STRING;
                        else if (c == ":") mode_next = M_COLON;
                        else if (c == "<") mode_next = M_LT;
                        else if (c == ">") mode_next = M_GT;
                        else if (c == "=") mode_next = M_EQ;
                        else if (c == "!") mode_next = M_BANG;
                        else
                        begin
                            t1.start = 16'(pos_reg);
                            t1.line = line_reg;
                            if (sk != 6'd0)
                            begin
                                t1.kind = sk;
                                t1.err = E_NONE;
                                t1.len = lenf(pos_reg, pos_reg, 1'b1);
                            end
                            else
                            begin
                                t1.kind = K_ERROR;
                                t1.err = E_UNEXP;
                                t1.len = '0;
                            end
                            if (fl)
                            begin
                                tb = t1;
                                n = 2'd2;
                            end
                            else
                            begin
                                ta = t1;
                                n = 2'd1;
                            end
                        end
                    end
                end
                if (pos_reg != CAP)
                    pos_next = pos_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_v_reg <= 1'b0;
            mode_reg <= M_IDLE;
            pos_reg  <= '0;
            st_reg   <= '0;
            line_reg <= 16'd1;
            wb_reg   <= '0;
            wl_reg   <= '0;
        end
        else
        begin
            in_v_reg <= char_valid && char_ready;
            mode_reg <= mode_next;
            pos_reg  <= pos_next;
            st_reg   <= st_next;
            line_reg <= line_next;
            wb_reg   <= wb_next;
            wl_reg   <= wl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (char_valid && char_ready)
            in_c_reg <= char_byte;
    end

    stt_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_v_reg),
        .push_n    (n),
        .push_a    (ta),
        .push_b    (tb),
        .space     (space),
        .out_valid (token_valid),
        .out_ready (token_ready),
        .out_tok   (oq),
        .out_last  (last_of_run)
    );

    assign token_kind   = oq.kind;
    assign error_kind   = oq.err;
    assign start_offset = oq.start;
    assign token_length = oq.len;
    assign line_number  = oq.line;

`ifndef SYNTH
    a_line_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        line_reg != 16'd0) else $error("line count zero");
    a_err_len: assert property (@(posedge clk) disable iff (!rst_n)
        token_valid && token_kind == K_ERROR |-> token_length == 16'd0)
        else $error("error token with length");
    a_eof_last: assert property (@(posedge clk) disable iff (!rst_n)
        token_valid && token_kind == K_EOF |-> last_of_run)
        else $error("eof not last");
`endif
endmodule
`default_nettype wire

@@ rtl/core/stt_outq.sv @@
`default_nettype none
module stt_outq (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire logic [1:0]    push_n,
    input  wire stt_pkg::tok_t push_a,
    input  wire stt_pkg::tok_t push_b,
    output logic               space,
    output logic               out_valid,
    input  wire logic          out_ready,
    output stt_pkg::tok_t      out_tok,
    output logic               out_last
);
    import stt_pkg::*;

    // four-entry queue of tokens; space means room for two more once this
    // cycle's push and pop have landed
    tok_t       q_reg [4];
    logic [3:0] lst_reg;
    logic [1:0] rd_reg, wr_reg;
    logic [2:0] cnt_reg;
    logic       pop;
    logic [2:0] cnt_next;

    assign pop       = out_valid && out_ready;
    assign out_valid = cnt_reg != 3'd0;
    assign out_tok   = q_reg[rd_reg];
    assign out_last  = lst_reg[rd_reg];
    assign space     = cnt_next <= 3'd2;

    always_comb
    begin
        cnt_next = cnt_reg - {2'd0, pop};
        if (push)
            cnt_next = cnt_next + {1'b0, push_n};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_reg  <= '0;
            wr_reg  <= '0;
            cnt_reg <= '0;
            lst_reg <= '0;
        end
        else
        begin
            if (pop)
                rd_reg <= rd_reg + 2'd1;
            if (push && push_n != 2'd0)
            begin
                q_reg[wr_reg]   <= push_a;
                lst_reg[wr_reg] <= push_n == 2'd1;
                if (push_n == 2'd2)
                begin
                    q_reg[wr_reg + 2'd1]   <= push_b;
                    lst_reg[wr_reg + 2'd1] <= 1'b1;
                end
                wr_reg <= wr_reg + push_n;
            end
            cnt_reg <= cnt_next;
        end
    end
endmodule
`default_nettype wire
